// ===== hdl/dfu_dsc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the dfu download sequence checker
package dfu_dsc_pkg;

  localparam int unsigned XFER_BYTES_DEF = 4096;

  localparam int unsigned FS_W      = 29;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLK_W     = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned ALT_W     = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SKIP_W    = 3;

  localparam logic [FS_W-1:0]   FLASH_SIZE_RST = FS_W'(262144);
  localparam logic [ADDR_W-1:0] APP_START_RST  = '0;
  localparam logic [WORD_W-1:0] IMAGE_SIG_RST  = '0;

  // signature word length in bytes
  localparam int unsigned SIG_BYTES = 4;

  typedef enum logic [1:0] {
    REQ_DOWNLOAD = 2'd0,
    REQ_MANIFEST = 2'd1,
    REQ_UPLOAD   = 2'd2,
    REQ_ABORT    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TARGET   = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_FILE     = 3'd3,
    ST_NOTDONE  = 3'd4,
    ST_FIRMWARE = 3'd5,
    ST_NONE     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE   = 2'd0,
    MEM_WRITE  = 2'd1,
    MEM_READ   = 2'd2,
    MEM_COMMIT = 2'd3
  } mem_op_e;

  typedef enum logic [1:0] {
    IND_UNCHANGED = 2'd0,
    IND_STARTED   = 2'd1,
    IND_FINISHED  = 2'd2
  } indicator_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLASH_SIZE = 2'd0,
    CFG_APP_START  = 2'd1,
    CFG_IMAGE_SIG  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [ALT_W-1:0]   alt_setting;
    logic [BLK_W-1:0]   block_index;
    logic [LEN_W-1:0]   req_length;
    logic [WORD_W-1:0]  first_word;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               flash_abort;
    logic               invalidate_app;
    mem_op_e            mem_op;
    logic [ADDR_W-1:0]  mem_address;
    logic [LEN_W-1:0]   mem_length;
    logic [SKIP_W-1:0]  source_skip;
    indicator_e         indicator;
    logic               reboot_request;
  } rsp_t;

  typedef struct packed {
    logic [FS_W-1:0]    flash_size;
    logic [ADDR_W-1:0]  app_start;
    logic [WORD_W-1:0]  image_signature;
  } cfg_t;

  typedef struct packed {
    logic               download_started;
    logic               download_failed;
    logic               signature_ok;
    logic [CNT_W-1:0]   bytes_received;
  } session_t;

endpackage

// ===== hdl/dfu_dsc_if.sv =====
`timescale 1ns / 1ps
// request, response and configuration channel interfaces
interface dfu_dsc_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [dfu_dsc_pkg::ALT_W-1:0]    alt_setting;
  logic [dfu_dsc_pkg::BLK_W-1:0]    block_index;
  logic [dfu_dsc_pkg::LEN_W-1:0]    req_length;
  logic [dfu_dsc_pkg::WORD_W-1:0]   first_word;

  modport source (
    output valid, req_type, alt_setting, block_index, req_length, first_word,
    input  ready
  );
  modport sink (
    input  valid, req_type, alt_setting, block_index, req_length, first_word,
    output ready
  );
endinterface

interface dfu_dsc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       status;
  logic                             flash_abort;
  logic                             invalidate_app;
  logic [1:0]                       mem_op;
  logic [dfu_dsc_pkg::ADDR_W-1:0]   mem_address;
  logic [dfu_dsc_pkg::LEN_W-1:0]    mem_length;
  logic [dfu_dsc_pkg::SKIP_W-1:0]   source_skip;
  logic [1:0]                       indicator;
  logic                             reboot_request;

  modport source (
    output valid, status, flash_abort, invalidate_app, mem_op, mem_address,
           mem_length, source_skip, indicator, reboot_request,
    input  ready
  );
  modport sink (
    input  valid, status, flash_abort, invalidate_app, mem_op, mem_address,
           mem_length, source_skip, indicator, reboot_request,
    output ready
  );
endinterface

interface dfu_dsc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dfu_dsc_pkg::CFG_IDX_W-1:0]   index;
  logic [dfu_dsc_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/dfu_dsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// configuration registers: flash size, image start address, image signature
module dfu_dsc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  dfu_dsc_cfg_if.sink         cfg_i,
  output dfu_dsc_pkg::cfg_t   cfg_o
);

  dfu_dsc_pkg::cfg_t cfg_q, cfg_d;
  logic              wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_i.index)
        dfu_dsc_pkg::CFG_FLASH_SIZE: begin
          cfg_d.flash_size = cfg_i.data[dfu_dsc_pkg::FS_W-1:0];
        end
        dfu_dsc_pkg::CFG_APP_START: begin
          cfg_d.app_start = cfg_i.data[dfu_dsc_pkg::ADDR_W-1:0];
        end
        dfu_dsc_pkg::CFG_IMAGE_SIG: begin
          cfg_d.image_signature = cfg_i.data[dfu_dsc_pkg::WORD_W-1:0];
        end
        default: begin
          // writes to unused indexes are dropped
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_size      <= dfu_dsc_pkg::FLASH_SIZE_RST;
      cfg_q.app_start       <= dfu_dsc_pkg::APP_START_RST;
      cfg_q.image_signature <= dfu_dsc_pkg::IMAGE_SIG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/dfu_dsc_eval.sv =====
`timescale 1ns / 1ps
// session state and the combinational evaluation of one request
module dfu_dsc_eval #(
  parameter int unsigned XFER_BYTES = dfu_dsc_pkg::XFER_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  dfu_dsc_pkg::req_t     req_i,
  input  dfu_dsc_pkg::cfg_t     cfg_i,
  output dfu_dsc_pkg::rsp_t     rsp_o
);

  localparam int unsigned OfsW = dfu_dsc_pkg::BLK_W + $clog2(XFER_BYTES + 1);
  localparam int unsigned CmpW = (OfsW > dfu_dsc_pkg::CNT_W) ? OfsW + 1
                                                             : dfu_dsc_pkg::CNT_W + 1;
  localparam int unsigned LenW = dfu_dsc_pkg::LEN_W;

  dfu_dsc_pkg::session_t sess_q, sess_d, base;

  logic [OfsW-1:0] offset;
  logic [CmpW-1:0] off_x, fs_x, len_x, rcv_x, room;
  logic            blk_zero, alt_bad, off_past_fs, addr_bad;
  logic [LenW-1:0] up_len;

  assign offset   = OfsW'(req_i.block_index) * OfsW'(XFER_BYTES);
  assign off_x    = CmpW'(offset);
  assign fs_x     = CmpW'(cfg_i.flash_size);
  assign len_x    = CmpW'(req_i.req_length);
  assign blk_zero = (req_i.block_index == '0);
  assign alt_bad  = (req_i.alt_setting != '0);

  // block 0 restarts the session before the address, file and order checks
  always_comb begin
    base = sess_q;
    if (blk_zero) begin
      base = '0;
    end
  end

  assign rcv_x       = CmpW'(base.bytes_received);
  assign off_past_fs = off_x > fs_x;
  assign room        = fs_x - off_x;
  assign addr_bad    = (off_x != rcv_x) || (req_i.req_length == '0) || off_past_fs
                       || (len_x > room);
  assign up_len      = (room < len_x) ? room[LenW-1:0] : req_i.req_length;

  always_comb begin
    rsp_o  = '0;
    sess_d = sess_q;
    case (req_i.req_type)
      dfu_dsc_pkg::REQ_DOWNLOAD: begin
        if (alt_bad) begin
          sess_d.download_failed = 1'b1;
          rsp_o.status           = dfu_dsc_pkg::ST_TARGET;
          rsp_o.flash_abort      = 1'b1;
          rsp_o.indicator        = dfu_dsc_pkg::IND_FINISHED;
        end else begin
          sess_d            = base;
          rsp_o.flash_abort = blk_zero;
          if (addr_bad || (blk_zero && ((req_i.req_length < LenW'(dfu_dsc_pkg::SIG_BYTES))
              || (req_i.first_word != cfg_i.image_signature)))
              || (!blk_zero && !base.download_started)) begin
            sess_d.download_failed = 1'b1;
            rsp_o.flash_abort      = 1'b1;
            rsp_o.indicator        = dfu_dsc_pkg::IND_FINISHED;
            if (addr_bad) begin
              rsp_o.status = dfu_dsc_pkg::ST_ADDRESS;
            end else if (blk_zero) begin
              rsp_o.status = dfu_dsc_pkg::ST_FILE;
            end else begin
              rsp_o.status = dfu_dsc_pkg::ST_NOTDONE;
            end
          end else if (blk_zero) begin
            sess_d.download_started = 1'b1;
            sess_d.signature_ok     = 1'b1;
            sess_d.bytes_received   = dfu_dsc_pkg::CNT_W'(req_i.req_length);
            rsp_o.invalidate_app    = 1'b1;
            rsp_o.mem_op            = dfu_dsc_pkg::MEM_WRITE;
            rsp_o.mem_address       = cfg_i.app_start
                                      + dfu_dsc_pkg::ADDR_W'(dfu_dsc_pkg::SIG_BYTES);
            rsp_o.mem_length        = req_i.req_length - LenW'(dfu_dsc_pkg::SIG_BYTES);
            rsp_o.source_skip       = dfu_dsc_pkg::SKIP_W'(dfu_dsc_pkg::SIG_BYTES);
            rsp_o.indicator         = dfu_dsc_pkg::IND_STARTED;
          end else begin
            sess_d.bytes_received = base.bytes_received
                                    + dfu_dsc_pkg::CNT_W'(req_i.req_length);
            rsp_o.mem_op          = dfu_dsc_pkg::MEM_WRITE;
            rsp_o.mem_address     = cfg_i.app_start + dfu_dsc_pkg::ADDR_W'(offset);
            rsp_o.mem_length      = req_i.req_length;
          end
        end
      end
      dfu_dsc_pkg::REQ_MANIFEST: begin
        if (alt_bad || !sess_q.download_started || sess_q.download_failed
            || !sess_q.signature_ok
            || (sess_q.bytes_received <= dfu_dsc_pkg::CNT_W'(dfu_dsc_pkg::SIG_BYTES))) begin
          sess_d.download_failed = 1'b1;
          rsp_o.status           = dfu_dsc_pkg::ST_FIRMWARE;
          rsp_o.flash_abort      = 1'b1;
          rsp_o.indicator        = dfu_dsc_pkg::IND_FINISHED;
        end else begin
          rsp_o.mem_op         = dfu_dsc_pkg::MEM_COMMIT;
          rsp_o.mem_address    = cfg_i.app_start;
          rsp_o.mem_length     = LenW'(dfu_dsc_pkg::SIG_BYTES);
          rsp_o.indicator      = dfu_dsc_pkg::IND_FINISHED;
          rsp_o.reboot_request = 1'b1;
        end
      end
      dfu_dsc_pkg::REQ_UPLOAD: begin
        rsp_o.status = dfu_dsc_pkg::ST_NONE;
        // zero length reply ends the upload
        if (!alt_bad && (off_x < fs_x)) begin
          rsp_o.mem_op      = dfu_dsc_pkg::MEM_READ;
          rsp_o.mem_address = cfg_i.app_start + dfu_dsc_pkg::ADDR_W'(offset);
          rsp_o.mem_length  = up_len;
        end
      end
      dfu_dsc_pkg::REQ_ABORT: begin
        rsp_o.status      = dfu_dsc_pkg::ST_NONE;
        rsp_o.flash_abort = 1'b1;
        rsp_o.indicator   = dfu_dsc_pkg::IND_FINISHED;
        sess_d            = '0;
      end
      default: begin
        rsp_o  = '0;
        sess_d = sess_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q <= '0;
    end else if (step_i) begin
      sess_q <= sess_d;
    end
  end

endmodule

// ===== hdl/dfu_download_sequence_checker_core.sv =====
`timescale 1ns / 1ps
// Top level of the DFU download sequence checker. Each accepted request yields
// exactly one response, and a new request can be accepted every cycle while the
// response path keeps up: the block sustains one request per clock. A request
// lands in an input register, is evaluated against the session state and the
// configuration in combinational logic, and its response is held in a result
// register, so a response is offered once its request has passed through the
// input register and the result register, later if a stalled response blocks it.
// That input register and result register around the single evaluation stage
// set the latency; a stalled response holds both stages and drops ready only
// when both are full. Configuration writes are taken every cycle and should be
// made while no request is in flight.
module dfu_download_sequence_checker_core #(
  parameter int unsigned XFER_BYTES = dfu_dsc_pkg::XFER_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dfu_dsc_req_if.sink   req_i,
  dfu_dsc_rsp_if.source rsp_o,
  dfu_dsc_cfg_if.sink   cfg_i
);

  dfu_dsc_pkg::cfg_t cfg;
  dfu_dsc_pkg::req_t req_q, req_in;
  dfu_dsc_pkg::rsp_t rsp_q, rsp_d;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_xfer;

  dfu_dsc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_xfer     = req_i.valid && req_i.ready;

  assign req_in.req_type    = dfu_dsc_pkg::req_type_e'(req_i.req_type);
  assign req_in.alt_setting = req_i.alt_setting;
  assign req_in.block_index = req_i.block_index;
  assign req_in.req_length  = req_i.req_length;
  assign req_in.first_word  = req_i.first_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_in;
    end
  end

  dfu_dsc_eval #(
    .XFER_BYTES (XFER_BYTES)
  ) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.flash_abort    = rsp_q.flash_abort;
  assign rsp_o.invalidate_app = rsp_q.invalidate_app;
  assign rsp_o.mem_op         = rsp_q.mem_op;
  assign rsp_o.mem_address    = rsp_q.mem_address;
  assign rsp_o.mem_length     = rsp_q.mem_length;
  assign rsp_o.source_skip    = rsp_q.source_skip;
  assign rsp_o.indicator      = rsp_q.indicator;
  assign rsp_o.reboot_request = rsp_q.reboot_request;

endmodule

// ===== bench/tb_dfu_download_sequence_checker_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the dfu download sequence checker core
module tb_dfu_download_sequence_checker_core;
  import dfu_dsc_pkg::*;

  localparam int unsigned XFER        = XFER_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    req_t rq;
    bit   pinned;
    rsp_t rs;
  } row_t;

  typedef struct {
    bit   on;
    rsp_t rs;
  } pin_t;

  logic clk_i;
  logic rst_ni;

  dfu_dsc_req_if req_if ();
  dfu_dsc_rsp_if rsp_if ();
  dfu_dsc_cfg_if cfg_if ();

  dfu_download_sequence_checker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow copies of the registers and the download session
  cfg_t     regs;
  session_t sess;

  rsp_t awaited_rsp[$];
  pin_t pinned_rsp[$];
  req_t stim_q[$];
  row_t dir_rows[$];
  int   errors = 0;
  int   cycles = 0;
  bit   hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic req_t mk_req(req_type_e t, logic [ALT_W-1:0] a, logic [BLK_W-1:0] b,
                                  logic [LEN_W-1:0] l, logic [WORD_W-1:0] w);
    req_t r;
    r.req_type    = t;
    r.alt_setting = a;
    r.block_index = b;
    r.req_length  = l;
    r.first_word  = w;
    return r;
  endfunction

  function automatic rsp_t rsp_of(status_e st, logic ab, logic inv, mem_op_e op,
                                  logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
                                  logic [SKIP_W-1:0] sk, indicator_e ind, logic rb);
    rsp_t o;
    o.status         = st;
    o.flash_abort    = ab;
    o.invalidate_app = inv;
    o.mem_op         = op;
    o.mem_address    = a;
    o.mem_length     = l;
    o.source_skip    = sk;
    o.indicator      = ind;
    o.reboot_request = rb;
    return o;
  endfunction

  // error responses and abort share the same shape
  function automatic rsp_t err_rsp(status_e st);
    return rsp_of(st, 1'b1, 1'b0, MEM_NONE, '0, '0, '0, IND_FINISHED, 1'b0);
  endfunction

  function automatic void mark_failed(inout rsp_t o, input status_e st);
    sess.download_failed = 1'b1;
    o.status      = st;
    o.flash_abort = 1'b1;
    o.indicator   = IND_FINISHED;
  endfunction

  function automatic rsp_t dfu_response_for(req_t r);
    rsp_t        o;
    logic [63:0] offs;
    logic [63:0] fsz;
    logic [63:0] room;
    o    = rsp_of(ST_OK, 1'b0, 1'b0, MEM_NONE, '0, '0, '0, IND_UNCHANGED, 1'b0);
    offs = 64'(r.block_index) * 64'(XFER);
    fsz  = 64'(regs.flash_size);
    case (r.req_type)
      REQ_DOWNLOAD: begin
        if (r.alt_setting != '0) begin
          mark_failed(o, ST_TARGET);
        end else begin
          // block 0 restarts the session before any check
          if (r.block_index == '0) begin
            o.flash_abort = 1'b1;
            sess = '0;
          end
          if (offs != 64'(sess.bytes_received) || r.req_length == '0 || offs > fsz
              || 64'(r.req_length) > fsz - offs) begin
            mark_failed(o, ST_ADDRESS);
          end else if (r.block_index == '0) begin
            if (r.req_length < LEN_W'(SIG_BYTES) || r.first_word != regs.image_signature) begin
              mark_failed(o, ST_FILE);
            end else begin
              sess.download_started = 1'b1;
              sess.signature_ok     = 1'b1;
              o.invalidate_app      = 1'b1;
              o.mem_op              = MEM_WRITE;
              o.mem_address         = regs.app_start + ADDR_W'(SIG_BYTES);
              o.mem_length          = r.req_length - LEN_W'(SIG_BYTES);
              o.source_skip         = SKIP_W'(SIG_BYTES);
              o.indicator           = IND_STARTED;
              sess.bytes_received   = sess.bytes_received + CNT_W'(r.req_length);
            end
          end else if (!sess.download_started) begin
            mark_failed(o, ST_NOTDONE);
          end else begin
            o.mem_op            = MEM_WRITE;
            o.mem_address       = regs.app_start + offs[ADDR_W-1:0];
            o.mem_length        = r.req_length;
            sess.bytes_received = sess.bytes_received + CNT_W'(r.req_length);
          end
        end
      end
      REQ_MANIFEST: begin
        if (r.alt_setting != '0 || !sess.download_started || sess.download_failed
            || !sess.signature_ok || sess.bytes_received <= CNT_W'(SIG_BYTES)) begin
          mark_failed(o, ST_FIRMWARE);
        end else begin
          o.mem_op         = MEM_COMMIT;
          o.mem_address    = regs.app_start;
          o.mem_length     = LEN_W'(SIG_BYTES);
          o.indicator      = IND_FINISHED;
          o.reboot_request = 1'b1;
        end
      end
      REQ_UPLOAD: begin
        o.status = ST_NONE;
        if (r.alt_setting == '0 && offs < fsz) begin
          room = fsz - offs;
          if (room > 64'(r.req_length)) room = 64'(r.req_length);
          o.mem_op      = MEM_READ;
          o.mem_address = regs.app_start + offs[ADDR_W-1:0];
          o.mem_length  = room[LEN_W-1:0];
        end
      end
      default: begin
        o    = err_rsp(ST_NONE);
        sess = '0;
      end
    endcase
    return o;
  endfunction

  task automatic check_rsp(input rsp_t want, input rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.flash_abort !== want.flash_abort) begin
      $error("flash_abort: expected %0d, got %0d", want.flash_abort, got.flash_abort);
      errors++;
    end
    if (got.invalidate_app !== want.invalidate_app) begin
      $error("invalidate_app: expected %0d, got %0d", want.invalidate_app, got.invalidate_app);
      errors++;
    end
    if (got.mem_op !== want.mem_op) begin
      $error("mem_op: expected %0d, got %0d", want.mem_op, got.mem_op);
      errors++;
    end
    if (got.mem_address !== want.mem_address) begin
      $error("mem_address: expected %h, got %h", want.mem_address, got.mem_address);
      errors++;
    end
    if (got.mem_length !== want.mem_length) begin
      $error("mem_length: expected %0d, got %0d", want.mem_length, got.mem_length);
      errors++;
    end
    if (got.source_skip !== want.source_skip) begin
      $error("source_skip: expected %0d, got %0d", want.source_skip, got.source_skip);
      errors++;
    end
    if (got.indicator !== want.indicator) begin
      $error("indicator: expected %0d, got %0d", want.indicator, got.indicator);
      errors++;
    end
    if (got.reboot_request !== want.reboot_request) begin
      $error("reboot_request: expected %0d, got %0d", want.reboot_request, got.reboot_request);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    req_t rq;
    rsp_t want;
    rsp_t got;
    pin_t pin;
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_index_e'(cfg_if.index))
        CFG_FLASH_SIZE: regs.flash_size      = cfg_if.data[FS_W-1:0];
        CFG_APP_START:  regs.app_start       = cfg_if.data;
        CFG_IMAGE_SIG:  regs.image_signature = cfg_if.data;
        default: ;
      endcase
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      rq   = mk_req(req_type_e'(req_if.req_type), req_if.alt_setting, req_if.block_index,
                    req_if.req_length, req_if.first_word);
      want = dfu_response_for(rq);
      // directed rows may carry a hand-written expectation
      if (pinned_rsp.size() != 0) begin
        pin = pinned_rsp.pop_front();
        if (pin.on) want = pin.rs;
      end
      awaited_rsp.push_back(want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_of(status_e'(rsp_if.status), rsp_if.flash_abort, rsp_if.invalidate_app,
                   mem_op_e'(rsp_if.mem_op), rsp_if.mem_address, rsp_if.mem_length,
                   rsp_if.source_skip, indicator_e'(rsp_if.indicator), rsp_if.reboot_request);
      if (awaited_rsp.size() == 0) begin
        $error("response transfer with nothing outstanding");
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        check_rsp(want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // response side stalls in spans of random style, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        while (span > 0 && !hold_off_req) begin
          case (mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= span[0];
          endcase
          span--;
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic drive_req(input req_t r);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req_type;
    req_if.alt_setting <= r.alt_setting;
    req_if.block_index <= r.block_index;
    req_if.req_length  <= r.req_length;
    req_if.first_word  <= r.first_word;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // the first `tight` items go out back to back, the rest in bursts
  task automatic send_items(input int tight);
    int i;
    int burst;
    int gap;
    i = 0;
    while (i < stim_q.size()) begin
      burst = (i < tight) ? tight : $urandom_range(1, 16);
      while (burst > 0 && i < stim_q.size()) begin
        drive_req(stim_q[i]);
        i++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && i < stim_q.size()) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    stim_q.delete();
  endtask

  task automatic settle();
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [FS_W-1:0] fs, input logic [ADDR_W-1:0] app,
                           input logic [WORD_W-1:0] sig);
    logic [CFG_DAT_W-1:0] vals [3];
    cfg_index_e           idx  [3];
    int                   k;
    idx[0]  = CFG_FLASH_SIZE;
    idx[1]  = CFG_APP_START;
    idx[2]  = CFG_IMAGE_SIG;
    // bits above the flash size field are don't-care
    vals[0] = {3'($urandom), fs};
    vals[1] = app;
    vals[2] = sig;
    for (k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= vals[k];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // one download session: in-order blocks, occasional damage, then mostly a closing request
  task automatic gen_session(input logic [FS_W-1:0] fs, input logic [WORD_W-1:0] sig);
    int               maxblk;
    int               nblk;
    int               i;
    int               n;
    logic [LEN_W-1:0] len;
    logic [WORD_W-1:0] word;
    logic [ALT_W-1:0] alt;
    logic [BLK_W-1:0] blk;
    maxblk = int'(fs / XFER) + 1;
    if (maxblk > 12) maxblk = 12;
    nblk = $urandom_range(1, maxblk);
    for (i = 0; i < nblk; i++) begin
      len  = (i < nblk - 1 || $urandom_range(0, 3) == 0) ? LEN_W'(XFER)
                                                         : LEN_W'($urandom_range(1, XFER));
      word = (i == 0 && $urandom_range(0, 7) != 0) ? sig : $urandom;
      alt  = '0;
      blk  = BLK_W'(i);
      case ($urandom_range(0, 19))
        0:       len = '0;
        1:       blk = blk + BLK_W'($urandom_range(1, 3));
        2:       alt = ALT_W'($urandom_range(1, 255));
        3:       len = LEN_W'($urandom_range(XFER + 1, 65535));
        default: ;
      endcase
      stim_q.push_back(mk_req(REQ_DOWNLOAD, alt, blk, len, word));
      if ($urandom_range(0, 7) == 0) begin
        stim_q.push_back(mk_req(REQ_UPLOAD, '0, BLK_W'($urandom_range(0, i + 1)),
                                LEN_W'($urandom), $urandom));
      end
    end
    case ($urandom_range(0, 9))
      7: stim_q.push_back(mk_req(REQ_ABORT, ALT_W'($urandom), BLK_W'($urandom),
                                 LEN_W'($urandom), $urandom));
      8: begin
        stim_q.push_back(mk_req(REQ_MANIFEST, '0, '0, '0, '0));
        stim_q.push_back(mk_req(REQ_MANIFEST, ($urandom_range(0, 1) == 0) ? '0 : ALT_W'($urandom),
                                BLK_W'($urandom), LEN_W'($urandom), $urandom));
      end
      9: ;
      default: stim_q.push_back(mk_req(REQ_MANIFEST, '0, BLK_W'($urandom), LEN_W'($urandom),
                                       $urandom));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        stim_q.push_back(mk_req(REQ_UPLOAD, '0, BLK_W'(i),
                                ($urandom_range(0, 1) == 0) ? LEN_W'(XFER) : LEN_W'($urandom),
                                $urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      stim_q.push_back(mk_req(req_type_e'($urandom_range(0, 3)),
                              ($urandom_range(0, 3) == 0) ? ALT_W'($urandom) : '0,
                              BLK_W'($urandom), LEN_W'($urandom), $urandom));
    end
  endtask

  task automatic add_row(input req_t rq, input bit pinned, input rsp_t rs);
    row_t row;
    row.rq     = rq;
    row.pinned = pinned;
    row.rs     = rs;
    dir_rows.push_back(row);
  endtask

  // directed rows under the reset configuration: 256 KiB flash, image at 0, signature 0
  task automatic build_directed();
    rsp_t idle_up;
    rsp_t none;
    idle_up = rsp_of(ST_NONE, 1'b0, 1'b0, MEM_NONE, '0, '0, '0, IND_UNCHANGED, 1'b0);
    none    = '0;
    add_row(mk_req(REQ_MANIFEST, '0, '0, '0, '0), 1'b1, err_rsp(ST_FIRMWARE));
    add_row(mk_req(REQ_DOWNLOAD, '0, 16'd1, 16'd4096, '0), 1'b1, err_rsp(ST_ADDRESS));
    add_row(mk_req(REQ_DOWNLOAD, 8'hFF, '0, 16'd4096, '0), 1'b1, err_rsp(ST_TARGET));
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, '0, '0), 1'b1, err_rsp(ST_ADDRESS));
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, 16'd3, '0), 1'b1, err_rsp(ST_FILE));
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, 16'd4096, 32'hFFFF_FFFF), 1'b1, err_rsp(ST_FILE));
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, 16'd4096, '0), 1'b1,
            rsp_of(ST_OK, 1'b1, 1'b1, MEM_WRITE, 32'd4, 16'd4092, 3'd4, IND_STARTED, 1'b0));
    add_row(mk_req(REQ_DOWNLOAD, '0, 16'd1, 16'd4096, 32'h1234_5678), 1'b0, none);
    add_row(mk_req(REQ_MANIFEST, '0, '0, '0, '0), 1'b1,
            rsp_of(ST_OK, 1'b0, 1'b0, MEM_COMMIT, '0, 16'd4, '0, IND_FINISHED, 1'b1));
    add_row(mk_req(REQ_UPLOAD, '0, '0, 16'hFFFF, '0), 1'b1,
            rsp_of(ST_NONE, 1'b0, 1'b0, MEM_READ, '0, 16'hFFFF, '0, IND_UNCHANGED, 1'b0));
    add_row(mk_req(REQ_UPLOAD, '0, 16'd63, 16'hFFFF, '0), 1'b0, none);
    add_row(mk_req(REQ_UPLOAD, '0, 16'd5, '0, '0), 1'b0, none);
    add_row(mk_req(REQ_UPLOAD, '0, 16'd64, 16'd64, '0), 1'b1, idle_up);
    add_row(mk_req(REQ_UPLOAD, '0, 16'hFFFF, 16'hFFFF, '0), 1'b1, idle_up);
    add_row(mk_req(REQ_UPLOAD, 8'h80, '0, 16'd512, '0), 1'b1, idle_up);
    add_row(mk_req(REQ_MANIFEST, 8'h01, '0, '0, '0), 1'b1, err_rsp(ST_FIRMWARE));
    add_row(mk_req(REQ_MANIFEST, '0, '0, '0, '0), 1'b1, err_rsp(ST_FIRMWARE));
    add_row(mk_req(REQ_ABORT, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
            err_rsp(ST_NONE));
    add_row(mk_req(REQ_DOWNLOAD, '0, 16'd2, 16'd4096, '0), 1'b1, err_rsp(ST_ADDRESS));
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, 16'hFFFF, '0), 1'b0, none);
    add_row(mk_req(REQ_DOWNLOAD, '0, 16'd16, 16'd1, '0), 1'b1, err_rsp(ST_ADDRESS));
    add_row(mk_req(REQ_MANIFEST, '0, '0, '0, '0), 1'b1, err_rsp(ST_FIRMWARE));
    // a session holding only the signature word cannot be manifested
    add_row(mk_req(REQ_DOWNLOAD, '0, '0, 16'd4, '0), 1'b1,
            rsp_of(ST_OK, 1'b1, 1'b1, MEM_WRITE, 32'd4, '0, 3'd4, IND_STARTED, 1'b0));
    add_row(mk_req(REQ_MANIFEST, '0, '0, '0, '0), 1'b1, err_rsp(ST_FIRMWARE));
  endtask

  initial begin : stimulus
    logic [FS_W-1:0]   fs;
    logic [ADDR_W-1:0] app;
    logic [WORD_W-1:0] sig;
    pin_t              pin;
    int                ph;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= '0;
    req_if.alt_setting <= '0;
    req_if.block_index <= '0;
    req_if.req_length  <= '0;
    req_if.first_word  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    regs.flash_size      = FLASH_SIZE_RST;
    regs.app_start       = APP_START_RST;
    regs.image_signature = IMAGE_SIG_RST;
    sess                 = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    foreach (dir_rows[i]) begin
      pin.on = dir_rows[i].pinned;
      pin.rs = dir_rows[i].rs;
      pinned_rsp.push_back(pin);
      stim_q.push_back(dir_rows[i].rq);
    end
    send_items(0);
    settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      app = $urandom;
      sig = $urandom;
      case (ph)
        0: begin
          fs  = '0;
          app = '0;
          sig = 32'hFFFF_FFFF;
        end
        1: fs = FS_W'(XFER * $urandom_range(2, 10));
        2: begin
          fs  = '1;
          app = 32'hFFFF_FFFF;
          sig = '0;
        end
        3: begin
          fs  = FS_W'(268435456);
          app = 32'hFFFF_F000;
        end
        4: fs = FS_W'($urandom_range(XFER, 12 * XFER));
        5: fs = FS_W'($urandom_range(1, 8));
        6: fs = FS_W'(XFER * $urandom_range(1, 12) + $urandom_range(1, XFER - 1));
        default: begin
          fs  = FLASH_SIZE_RST;
          app = APP_START_RST;
          sig = IMAGE_SIG_RST;
        end
      endcase
      apply_cfg(fs, app, sig);
      while (stim_q.size() < PHASE_ITEMS) gen_session(fs, sig);
      // long response stall while requests keep coming, so the input backs up
      if (ph == 4) hold_off_req = 1'b1;
      send_items((ph == 4) ? 24 : 0);
      settle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
